[hw/rtl/cmpc_pkg.sv]
package cmpc_pkg;

  localparam int CH_W      = 8;
  localparam int SUM_W     = 20;
  localparam int THR_W     = 9;
  localparam int PIX_W     = 13;
  localparam int CLS_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  localparam int PALETTE_DEPTH_DEF   = 16;
  localparam int MAX_CELL_PIXELS_DEF = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXELS    = 1'd1;

  localparam logic [THR_W-1:0] THR_RESET = 9'd15;
  localparam logic [PIX_W-1:0] PIX_RESET = 13'd900;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic mean_load;
    logic srch_clear;
    logic rd_issue;
    logic srch_next;
    logic hit;
    logic append;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic hit;
  } dp_sts_t;

endpackage

[hw/rtl/cmpc_ctrl.sv]
module cmpc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cell_end,
  output logic              out_valid,
  input  logic              out_stall,
  input  cmpc_pkg::dp_sts_t sts,
  output cmpc_pkg::dp_cmd_t cmd
);

  localparam logic [2:0] S_ACC    = 3'd0;
  localparam logic [2:0] S_DIV    = 3'd1;
  localparam logic [2:0] S_MEAN   = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_CMP    = 3'd4;
  localparam logic [2:0] S_APPEND = 3'd5;
  localparam logic [2:0] S_HOLD   = 3'd6;

  localparam logic [cmpc_pkg::DIV_CNT_W-1:0] DIV_LAST =
    cmpc_pkg::DIV_CNT_W'(cmpc_pkg::SUM_W - 1);

  logic [2:0]                     state;
  logic [2:0]                     state_next;
  logic [cmpc_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [cmpc_pkg::DIV_CNT_W-1:0] div_cnt_next;
  logic                           out_valid_next;
  logic                           in_beat;

  assign in_stall = (state != S_ACC);
  assign in_beat  = in_valid && !in_stall;

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    cmd.accept   = in_beat;
    unique case (state)
      S_ACC: begin
        if (in_beat && cell_end) begin
          div_cnt_next = '0;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_LAST) begin
          state_next = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd.mean_load  = 1'b1;
        cmd.srch_clear = 1'b1;
        state_next     = S_READ;
      end
      S_READ: begin
        if (sts.in_range) begin
          cmd.rd_issue = 1'b1;
          state_next   = S_CMP;
        end else begin
          state_next = S_APPEND;
        end
      end
      S_CMP: begin
        if (sts.hit) begin
          cmd.hit    = 1'b1;
          state_next = S_HOLD;
        end else begin
          cmd.srch_next = 1'b1;
          state_next    = S_READ;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_HOLD;
      end
      S_HOLD: begin
        // wait for the output register to free up
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_ACC;
        end
      end
      default: begin
        state_next = S_ACC;
      end
    endcase
  end

  assign out_valid_next = cmd.out_load ? 1'b1 : (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACC;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[hw/rtl/cmpc_datapath.sv]
module cmpc_datapath #(
  parameter int PALETTE_DEPTH   = cmpc_pkg::PALETTE_DEPTH_DEF,
  parameter int MAX_CELL_PIXELS = cmpc_pkg::MAX_CELL_PIXELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cmpc_pkg::dp_cmd_t                cmd,
  output cmpc_pkg::dp_sts_t                sts,
  input  logic                             cfg_we,
  input  logic [cmpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cmpc_pkg::PIX_W-1:0]       cfg_data,
  input  logic [cmpc_pkg::CH_W-1:0]        pixel_red,
  input  logic [cmpc_pkg::CH_W-1:0]        pixel_green,
  input  logic [cmpc_pkg::CH_W-1:0]        pixel_blue,
  input  logic                             frame_start,
  input  logic                             cell_end,
  output logic [cmpc_pkg::CLS_W-1:0]       class_index,
  output logic [cmpc_pkg::CH_W-1:0]        mean_red,
  output logic [cmpc_pkg::CH_W-1:0]        mean_green,
  output logic [cmpc_pkg::CH_W-1:0]        mean_blue,
  output logic                             new_class,
  output logic                             palette_overflow
);

  localparam int CH_W  = cmpc_pkg::CH_W;
  localparam int SUM_W = cmpc_pkg::SUM_W;
  localparam int PIX_W = cmpc_pkg::PIX_W;
  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
  localparam int IDX_W = $clog2(PALETTE_DEPTH);
  localparam logic [PIX_W-1:0] MAX_DIV = PIX_W'(MAX_CELL_PIXELS);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(PALETTE_DEPTH);

  // configuration
  logic [cmpc_pkg::THR_W-1:0] cfg_thr;
  logic [PIX_W-1:0]           cfg_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_thr <= cmpc_pkg::THR_RESET;
      cfg_pix <= cmpc_pkg::PIX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cmpc_pkg::REG_THRESHOLD: cfg_thr <= cfg_data[cmpc_pkg::THR_W-1:0];
        cmpc_pkg::REG_PIXELS:    cfg_pix <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [PIX_W-1:0] div_eff;

  always_comb begin
    if (cfg_pix == '0) begin
      div_eff = PIX_W'(1);
    end else if (32'(cfg_pix) > 32'(MAX_CELL_PIXELS)) begin
      div_eff = MAX_DIV;
    end else begin
      div_eff = cfg_pix;
    end
  end

  // per-channel accumulate and restoring divide, one quotient bit a cycle
  logic [CH_W-1:0]  pix   [3];
  logic [SUM_W-1:0] sum   [3];
  logic [SUM_W-1:0] dvd   [3];
  logic [SUM_W-1:0] quo   [3];
  logic [PIX_W-1:0] rem   [3];
  logic [CH_W-1:0]  mean  [3];
  logic [PIX_W-1:0] dvsr;

  assign pix[0] = pixel_red;
  assign pix[1] = pixel_green;
  assign pix[2] = pixel_blue;

  always_ff @(posedge clk) begin
    if (cmd.accept && cell_end) begin
      dvsr <= div_eff;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [SUM_W-1:0] sum_add;
    logic [PIX_W:0]   rem_sh;
    logic             q_bit;

    assign sum_add = sum[c] + SUM_W'(pix[c]);
    assign rem_sh  = {rem[c], dvd[c][SUM_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, dvsr});

    always_ff @(posedge clk) begin
      if (rst) begin
        sum[c] <= '0;
      end else if (cmd.accept) begin
        sum[c] <= cell_end ? '0 : sum_add;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.accept && cell_end) begin
        dvd[c] <= sum_add;
        rem[c] <= '0;
        quo[c] <= '0;
      end else if (cmd.div_step) begin
        dvd[c] <= {dvd[c][SUM_W-2:0], 1'b0};
        rem[c] <= q_bit ? PIX_W'(rem_sh - {1'b0, dvsr}) : rem_sh[PIX_W-1:0];
        quo[c] <= {quo[c][SUM_W-2:0], q_bit};
      end
    end

    // saturate to the channel range
    always_ff @(posedge clk) begin
      if (cmd.mean_load) begin
        mean[c] <= (|quo[c][SUM_W-1:CH_W]) ? {CH_W{1'b1}} : quo[c][CH_W-1:0];
      end
    end
  end

  // palette
  logic [3*CH_W-1:0] pal_mem [PALETTE_DEPTH];
  logic [3*CH_W-1:0] rd_data;
  logic [CNT_W-1:0]  pal_count;
  logic [CNT_W-1:0]  srch;
  logic              full;

  assign full         = (pal_count >= DEPTH_C);
  assign sts.in_range = (srch < pal_count);

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data <= pal_mem[srch[IDX_W-1:0]];
    end
    if (cmd.append && !full) begin
      pal_mem[pal_count[IDX_W-1:0]] <= {mean[0], mean[1], mean[2]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_count <= '0;
    end else if (cmd.accept && frame_start) begin
      pal_count <= '0;
    end else if (cmd.append && !full) begin
      pal_count <= pal_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_clear) begin
      srch <= '0;
    end else if (cmd.srch_next) begin
      srch <= srch + 1'b1;
    end
  end

  logic [CH_W-1:0] ent  [3];
  logic            near [3];

  assign ent[0] = rd_data[3*CH_W-1:2*CH_W];
  assign ent[1] = rd_data[2*CH_W-1:CH_W];
  assign ent[2] = rd_data[CH_W-1:0];

  for (genvar c = 0; c < 3; c++) begin : g_cmp
    logic [CH_W-1:0] dif;
    assign dif     = (mean[c] > ent[c]) ? (mean[c] - ent[c]) : (ent[c] - mean[c]);
    assign near[c] = ({1'b0, dif} < cfg_thr);
  end

  assign sts.hit = near[0] && near[1] && near[2];

  // search outcome
  logic [CNT_W-1:0] res_cls;
  logic             res_new;
  logic             res_over;

  always_ff @(posedge clk) begin
    if (cmd.hit) begin
      res_cls  <= srch;
      res_new  <= 1'b0;
      res_over <= 1'b0;
    end else if (cmd.append) begin
      res_cls  <= full ? '0 : pal_count;
      res_new  <= !full;
      res_over <= full;
    end
  end

  logic [CNT_W+cmpc_pkg::CLS_W-1:0] cls_wide;
  assign cls_wide = {{cmpc_pkg::CLS_W{1'b0}}, res_cls};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      class_index      <= cls_wide[cmpc_pkg::CLS_W-1:0];
      mean_red         <= mean[0];
      mean_green       <= mean[1];
      mean_blue        <= mean[2];
      new_class        <= res_new;
      palette_overflow <= res_over;
    end
  end

endmodule

[hw/rtl/cell_mean_color_palette_classifier_core.sv]
// pixels: one beat per cycle while a cell accumulates
// cell end: input stalls through the divide, a mean load, a read and compare per palette
// entry checked, an append on a miss, and a hold while a stalled result waits; the input
// is released in the same cycle the result becomes valid
// reset clears channel sums, palette count and registers (threshold 15, 900 pixels);
// palette contents are not cleared
module cell_mean_color_palette_classifier_core #(
  parameter int PALETTE_DEPTH   = cmpc_pkg::PALETTE_DEPTH_DEF,
  parameter int MAX_CELL_PIXELS = cmpc_pkg::MAX_CELL_PIXELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cmpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cmpc_pkg::PIX_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cmpc_pkg::CH_W-1:0]      pixel_red,
  input  logic [cmpc_pkg::CH_W-1:0]      pixel_green,
  input  logic [cmpc_pkg::CH_W-1:0]      pixel_blue,
  input  logic                           frame_start,
  input  logic                           cell_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cmpc_pkg::CLS_W-1:0]     class_index,
  output logic [cmpc_pkg::CH_W-1:0]      mean_red,
  output logic [cmpc_pkg::CH_W-1:0]      mean_green,
  output logic [cmpc_pkg::CH_W-1:0]      mean_blue,
  output logic                           new_class,
  output logic                           palette_overflow
);

  cmpc_pkg::dp_cmd_t cmd;
  cmpc_pkg::dp_sts_t sts;

  cmpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cell_end  (cell_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cmpc_datapath #(
    .PALETTE_DEPTH   (PALETTE_DEPTH),
    .MAX_CELL_PIXELS (MAX_CELL_PIXELS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pixel_red        (pixel_red),
    .pixel_green      (pixel_green),
    .pixel_blue       (pixel_blue),
    .frame_start      (frame_start),
    .cell_end         (cell_end),
    .class_index      (class_index),
    .mean_red         (mean_red),
    .mean_green       (mean_green),
    .mean_blue        (mean_blue),
    .new_class        (new_class),
    .palette_overflow (palette_overflow)
  );

endmodule

[hw/rtl/cmpc_checker.sv]
module cmpc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       cell_end,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [cmpc_pkg::CLS_W-1:0] class_index,
  input logic                       new_class,
  input logic                       palette_overflow
);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(class_index)
                               && $stable(new_class) && $stable(palette_overflow))
    else $error("result beat changed while stalled");

  // overflow never comes with a new entry and always reports class zero
  a_over_cls: assert property (@(posedge clk) disable iff (rst)
    out_valid && palette_overflow |-> !new_class && class_index == '0)
    else $error("overflow result malformed");

  // the last pixel of a cell starts the divide, so input must stall
  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cell_end |=> in_stall)
    else $error("input not stalled after cell end");

  // input stays stalled past the first divide step after a cell end
  a_end_busy2: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cell_end ##1 !rst |=> in_stall)
    else $error("input released too early after cell end");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("outputs not idle after reset");

endmodule

bind cell_mean_color_palette_classifier_core cmpc_checker u_chk (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .cell_end         (cell_end),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .class_index      (class_index),
  .new_class        (new_class),
  .palette_overflow (palette_overflow)
);
